### design/phpd_pkg.sv
`timescale 1ns / 1ps

package phpd_pkg;

	// Sample and result field widths.
	localparam int SAMPLE_BITS = 14;
	localparam int AMP_BITS    = 18;
	localparam int INDEX_BITS  = 8;
	localparam int SEP_BITS    = 8;

	// Default trace geometry.
	localparam int PREGATE_DEF            = 25;
	localparam int NEIGHBOUR_DISTANCE_DEF = 6;
	localparam int MAX_SAMPLES_DEF        = 256;

	// Configuration register map.
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 14;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_VALLEY_DEPTH   = 1'b0,
		REG_MIN_SEPARATION = 1'b1
	} cfg_reg_t;

	localparam logic [SAMPLE_BITS-1:0] VALLEY_DEPTH_RST   = 14'd50;
	localparam logic [SEP_BITS-1:0]    MIN_SEPARATION_RST = 8'd30;

endpackage

### design/pulse_height_pileup_detector_core.sv
`timescale 1ns / 1ps

// Pulse height and pileup detector for digitizer traces.
// Input channel: one sample per item (sample, last_sample), handshake in_valid /
// in_stall. Output channel: one result per trace (amplitude, min_index, pileup),
// handshake out_valid / out_stall. An item moves when valid is high and stall low.
// Throughput: one sample per clock while in_stall is low. The per-trace state
// (baseline sum, minimum, valley tracker, sample delay line) is updated from the
// registered sample, so the accumulator loop sets the one-sample-per-cycle rate.
// A last sample moves from the input register through the trace close stage,
// the reciprocal multiply stage, then subtract and saturate into the output
// register, where it raises out_valid.
// Each result stage only waits when the stage after it is full, so samples
// keep flowing while a finished result is held by out_stall; in_stall rises
// only when a last sample finds the result pipeline full.
// The user writes configuration (cfg_we, cfg_index, cfg_data) between traces
// while idle; the block does not enforce this. Reset restores valley_depth = 50,
// min_separation = 30, empties every stage and starts a new trace.
module pulse_height_pileup_detector_core
	import phpd_pkg::*;
#(
	parameter int PREGATE            = PREGATE_DEF,
	parameter int NEIGHBOUR_DISTANCE = NEIGHBOUR_DISTANCE_DEF,
	parameter int MAX_SAMPLES        = MAX_SAMPLES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic                      last_sample,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [AMP_BITS-1:0]       amplitude,
	output logic [INDEX_BITS-1:0]     min_index,
	output logic                      pileup,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int WIN_LEN = 2 * NEIGHBOUR_DISTANCE;
	localparam int CW      = $clog2(MAX_SAMPLES + 1);
	localparam int PW      = $clog2(MAX_SAMPLES);
	localparam int DW      = (PW > SEP_BITS) ? PW : SEP_BITS;
	localparam int BW      = SAMPLE_BITS + $clog2(PREGATE);
	localparam int XW      = BW + 4;
	localparam int DIV_SHIFT = XW + $clog2(PREGATE);
	localparam int MW      = XW + 1;
	localparam int PRW     = XW + MW;
	localparam int QW      = PRW - DIV_SHIFT;
	localparam int MINW    = SAMPLE_BITS + 4;
	localparam int EW      = (QW > MINW) ? QW : MINW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << DIV_SHIFT) + 64'(PREGATE) - 64'd1) / 64'(PREGATE));
	localparam logic [EW-1:0] AMP_SAT = EW'((64'd1 << AMP_BITS) - 64'd1);

	// Configuration registers
	logic [SAMPLE_BITS-1:0] valley_depth_q;
	logic [SEP_BITS-1:0]    min_separation_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valley_depth_q   <= VALLEY_DEPTH_RST;
			min_separation_q <= MIN_SEPARATION_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VALLEY_DEPTH:   valley_depth_q   <= cfg_data[SAMPLE_BITS-1:0];
				REG_MIN_SEPARATION: min_separation_q <= cfg_data[SEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Flow control
	logic valid_s1, last_s1, valid_s2, valid_s3, out_valid_q;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic free_o, free_s3, free_s2, adv_s1, load_s1;

	assign free_o   = !out_valid_q || !out_stall;
	assign free_s3  = !valid_s3 || free_o;
	assign free_s2  = !valid_s2 || free_s3;
	assign adv_s1   = valid_s1 && (!last_s1 || free_s2);
	assign load_s1  = !valid_s1 || adv_s1;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			sample_s1 <= sample;
			last_s1   <= last_sample;
		end
	end

	// Per-trace state
	logic [BW-1:0]          base_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [PW-1:0]          min_pos_q;
	logic [CW-1:0]          cnt_q;
	logic [SAMPLE_BITS-1:0] win_q [WIN_LEN];
	logic [PW-1:0]          last_valley_q;
	logic                   valley_seen_q;
	logic                   pileup_q;

	logic                   active;
	logic [PW-1:0]          pos;
	logic [PW-1:0]          cpos;
	logic [SAMPLE_BITS:0]   floor_lvl;
	logic                   is_valley;
	logic [BW-1:0]          base_nx;
	logic [SAMPLE_BITS-1:0] min_nx;
	logic [PW-1:0]          min_pos_nx;
	logic                   pileup_nx;

	always_comb begin
		active     = cnt_q < CW'(MAX_SAMPLES);
		pos        = cnt_q[PW-1:0];
		cpos       = pos - PW'(NEIGHBOUR_DISTANCE);
		floor_lvl  = {1'b0, win_q[NEIGHBOUR_DISTANCE-1]} + {1'b0, valley_depth_q};
		// Both neighbours must sit above the centre by more than the depth.
		is_valley  = active && (cnt_q >= CW'(WIN_LEN)) && !pileup_q
			&& ({1'b0, win_q[WIN_LEN-1]} > floor_lvl)
			&& ({1'b0, sample_s1} > floor_lvl);
		base_nx    = base_q;
		min_nx     = min_q;
		min_pos_nx = min_pos_q;
		pileup_nx  = pileup_q;
		if (active && (int'(cnt_q) < PREGATE)) begin
			base_nx = base_q + BW'(sample_s1);
		end
		if (active && (sample_s1 < min_q)) begin
			min_nx     = sample_s1;
			min_pos_nx = pos;
		end
		if (is_valley && valley_seen_q
				&& (DW'(cpos - last_valley_q) > DW'(min_separation_q))) begin
			pileup_nx = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= '0;
			min_q         <= '1;
			min_pos_q     <= '0;
			cnt_q         <= '0;
			last_valley_q <= '0;
			valley_seen_q <= 1'b0;
			pileup_q      <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				base_q        <= '0;
				min_q         <= '1;
				min_pos_q     <= '0;
				cnt_q         <= '0;
				last_valley_q <= '0;
				valley_seen_q <= 1'b0;
				pileup_q      <= 1'b0;
			end else if (active) begin
				base_q    <= base_nx;
				min_q     <= min_nx;
				min_pos_q <= min_pos_nx;
				cnt_q     <= cnt_q + 1'b1;
				pileup_q  <= pileup_nx;
				if (is_valley) begin
					last_valley_q <= cpos;
					valley_seen_q <= 1'b1;
				end
			end
		end
	end

	// Delay line of the last 2*D samples; entries are only read once full.
	always_ff @(posedge clk) begin
		if (adv_s1 && active) begin
			win_q[0] <= sample_s1;
			for (int k = 1; k < WIN_LEN; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// Trace close stage
	logic [BW-1:0]          base_s2;
	logic [SAMPLE_BITS-1:0] min_s2;
	logic [INDEX_BITS-1:0]  idx_s2;
	logic                   pileup_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free_s2) begin
			valid_s2 <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s2 && adv_s1 && last_s1) begin
			base_s2   <= base_nx;
			min_s2    <= min_nx;
			idx_s2    <= INDEX_BITS'(min_pos_nx);
			pileup_s2 <= pileup_nx;
		end
	end

	// Division by PREGATE as a multiply by a rounded-up reciprocal, exact for XW bits.
	logic [PRW-1:0]         prod_s3;
	logic [SAMPLE_BITS-1:0] min_s3;
	logic [INDEX_BITS-1:0]  idx_s3;
	logic                   pileup_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (free_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3 && valid_s2) begin
			prod_s3   <= PRW'({base_s2, 4'b0000}) * PRW'(RECIP);
			min_s3    <= min_s2;
			idx_s3    <= idx_s2;
			pileup_s3 <= pileup_s2;
		end
	end

	// Subtract the minimum, clamp at zero and saturate.
	logic [EW-1:0] avg16, min16, amp_raw;
	logic [AMP_BITS-1:0]   amplitude_q;
	logic [INDEX_BITS-1:0] min_index_q;
	logic                  pileup_res_q;

	always_comb begin
		avg16   = EW'(prod_s3[PRW-1:DIV_SHIFT]);
		min16   = EW'({min_s3, 4'b0000});
		amp_raw = (avg16 > min16) ? (avg16 - min16) : '0;
		if (amp_raw > AMP_SAT) begin
			amp_raw = AMP_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free_o) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (free_o && valid_s3) begin
			amplitude_q  <= amp_raw[AMP_BITS-1:0];
			min_index_q  <= idx_s3;
			pileup_res_q <= pileup_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign amplitude = amplitude_q;
	assign min_index = min_index_q;
	assign pileup    = pileup_res_q;

	// A closed trace always starts the next one from position zero.
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> cnt_q == '0)
		else $error("sample count not cleared after trace close");

	// The position counter never runs past the trace limit.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SAMPLES))
		else $error("sample count above limit");

	// Back-pressure only comes from a held last sample facing a full result path.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && valid_s2 && valid_s3 && out_valid_q && out_stall)
		else $error("input stalled without a full result pipeline");

	// Pileup latches for the rest of a trace once set.
	a_pileup_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		pileup_q && !(adv_s1 && last_s1) |=> pileup_q)
		else $error("pileup flag dropped within a trace");

endmodule

### dv/pulse_height_pileup_detector_core_tb.sv
`timescale 1ns / 1ps

module pulse_height_pileup_detector_core_tb;
	import phpd_pkg::*;

	localparam int WIN_LEN     = 2 * NEIGHBOUR_DISTANCE_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MIN_ITEMS   = 1300;
	localparam int MIN_TRACES  = 28;

	typedef enum int {
		SHAPE_NOISE,
		SHAPE_SINGLE,
		SHAPE_DOUBLE
	} trace_shape_t;

	typedef struct packed {
		logic [AMP_BITS-1:0]   amplitude;
		logic [INDEX_BITS-1:0] min_index;
		logic                  pileup;
	} pulse_result_t;

	// Tracks the open trace and queues one expected pulse per closed trace.
	class pulse_scoreboard;
		logic [SAMPLE_BITS-1:0] valley_depth;
		logic [SEP_BITS-1:0]    min_separation;
		int unsigned            base_sum;
		logic [SAMPLE_BITS-1:0] min_val;
		int unsigned            min_pos;
		int unsigned            count;
		logic [SAMPLE_BITS-1:0] window [WIN_LEN];
		int unsigned            last_valley;
		bit                     valley_seen;
		bit                     pileup_flag;
		pulse_result_t          expected_pulses [$];
		int                     errors;
		int                     results_seen;
		int                     pileups_seen;

		function new();
			valley_depth   = VALLEY_DEPTH_RST;
			min_separation = MIN_SEPARATION_RST;
			errors         = 0;
			results_seen   = 0;
			pileups_seen   = 0;
			clear_trace();
		endfunction

		function void clear_trace();
			base_sum    = 0;
			min_val     = '1;
			min_pos     = 0;
			count       = 0;
			last_valley = 0;
			valley_seen = 1'b0;
			pileup_flag = 1'b0;
			foreach (window[k]) window[k] = '0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
			unique case (idx)
				REG_VALLEY_DEPTH: begin
					valley_depth = data[SAMPLE_BITS-1:0];
				end
				REG_MIN_SEPARATION: begin
					min_separation = data[SEP_BITS-1:0];
				end
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_pulses.size();
		endfunction

		function void note_sample(logic [SAMPLE_BITS-1:0] s, bit last);
			int unsigned   pos;
			int unsigned   centre;
			int unsigned   side;
			int unsigned   cpos;
			int unsigned   avg16;
			int unsigned   min16;
			int unsigned   amp;
			pulse_result_t r;
			if (count < MAX_SAMPLES_DEF) begin
				pos = count;
				if (pos < PREGATE_DEF)
					base_sum += s;
				if (s < min_val) begin
					min_val = s;
					min_pos = pos;
				end
				// The centre candidate lies NEIGHBOUR_DISTANCE back; its far neighbour
				// is the oldest entry of the window.
				if (pos >= WIN_LEN && !pileup_flag) begin
					centre = window[NEIGHBOUR_DISTANCE_DEF-1];
					side   = window[WIN_LEN-1];
					cpos   = pos - NEIGHBOUR_DISTANCE_DEF;
					if (side > centre + valley_depth && s > centre + valley_depth) begin
						if (valley_seen && cpos - last_valley > min_separation)
							pileup_flag = 1'b1;
						last_valley = cpos;
						valley_seen = 1'b1;
					end
				end
				for (int k = WIN_LEN - 1; k > 0; k--)
					window[k] = window[k-1];
				window[0] = s;
				count = pos + 1;
			end
			if (last) begin
				avg16 = (base_sum * 16) / PREGATE_DEF;
				min16 = min_val * 16;
				amp   = (avg16 > min16) ? avg16 - min16 : 0;
				if (amp > (1 << AMP_BITS) - 1)
					amp = (1 << AMP_BITS) - 1;
				r.amplitude = amp[AMP_BITS-1:0];
				r.min_index = min_pos[INDEX_BITS-1:0];
				r.pileup    = pileup_flag;
				expected_pulses.insert(expected_pulses.size(), r);
				clear_trace();
			end
		endfunction

		function void check_result(logic [AMP_BITS-1:0] amp, logic [INDEX_BITS-1:0] idx,
				logic pu);
			pulse_result_t r;
			results_seen++;
			if (expected_pulses.size() == 0) begin
				$error("result arrived with no closed trace pending");
				errors++;
				return;
			end
			r = expected_pulses.pop_front();
			if (r.pileup)
				pileups_seen++;
			if (amp !== r.amplitude) begin
				$error("amplitude mismatch: expected %0d, actual %0d", r.amplitude, amp);
				errors++;
			end
			if (idx !== r.min_index) begin
				$error("min_index mismatch: expected %0d, actual %0d", r.min_index, idx);
				errors++;
			end
			if (pu !== r.pileup) begin
				$error("pileup mismatch: expected %0d, actual %0d", r.pileup, pu);
				errors++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [SAMPLE_BITS-1:0]    sample;
	logic                      last_sample;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [AMP_BITS-1:0]       amplitude;
	logic [INDEX_BITS-1:0]     min_index;
	logic                      pileup;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	pulse_scoreboard sb = new();
	bit              quiet = 1'b0;
	int              cycles = 0;
	int              items_sent = 0;
	int              traces_sent = 0;
	int              overlong_traces = 0;
	int              settings = 1;

	pulse_height_pileup_detector_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.last_sample(last_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.amplitude  (amplitude),
		.min_index  (min_index),
		.pileup     (pileup),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic bit idle_now();
		return !quiet && ($urandom_range(99) < 29);
	endfunction

	always @(posedge clk) begin
		out_stall <= idle_now();
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(amplitude, min_index, pileup);
	end

	task automatic send_item(logic [SAMPLE_BITS-1:0] s, bit last);
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		sample      <= s;
		last_sample <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(s, last);
		items_sent++;
		if (last)
			traces_sent++;
	endtask

	// Waits until every closed trace has produced its pulse, then lets the
	// pipeline drain of any open-trace samples still in flight.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic run_trace(trace_shape_t shape, int len);
		int level;
		int noise;
		int depth;
		int half;
		int v;
		int gap;
		int dips;
		int i;
		int k;
		int c [2];
		level = $urandom_range(1500, 16300);
		noise = $urandom_range(0, 24);
		depth = ($urandom_range(3) == 0) ? level + noise : $urandom_range(40, level);
		half  = $urandom_range(2, 7);
		dips  = (shape == SHAPE_DOUBLE) ? 2 : 1;
		c[0]  = $urandom_range(0, (len - 1) / 2);
		c[1]  = c[0] + $urandom_range(1, len - 1 - c[0] > 1 ? len - 1 - c[0] : 1);
		for (i = 0; i < len; i++) begin
			if (shape == SHAPE_NOISE) begin
				v = $urandom_range(0, 16383);
			end else begin
				v = level + $urandom_range(0, noise);
				for (k = 0; k < dips; k++) begin
					gap = (i > c[k]) ? i - c[k] : c[k] - i;
					if (gap < half)
						v -= depth * (half - gap) / half;
				end
				if (v < 0)
					v = 0;
				if (v > 16383)
					v = 16383;
			end
			send_item(v[SAMPLE_BITS-1:0], i == len - 1);
		end
	endtask

	initial begin
		int           phase;
		int           t;
		int           roll;
		int           len;
		trace_shape_t shape;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		sample      <= '0;
		last_sample <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= REG_VALLEY_DEPTH;
		cfg_data    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed traces under the reset settings. A lone full-scale sample never
		// becomes a minimum and leaves the short baseline below it.
		send_item(14'h3FFF, 1'b1);
		send_item(14'h0000, 1'b1);
		// A deep valley at the earliest position where both neighbours exist.
		for (int i = 0; i < 14; i++)
			send_item((i == NEIGHBOUR_DISTANCE_DEF) ? 14'h0000 : 14'h3FFF, i == 13);
		// Repeated minimum: the first position is reported.
		send_item(14'd100, 1'b0);
		send_item(14'd50, 1'b0);
		send_item(14'd50, 1'b0);
		send_item(14'd80, 1'b0);
		send_item(14'd50, 1'b1);

		phase = 0;
		while (items_sent < MIN_ITEMS || traces_sent < MIN_TRACES) begin
			unique case (phase % 8)
				0: ;
				1: begin
					write_reg(REG_VALLEY_DEPTH, 14'd0);
					write_reg(REG_MIN_SEPARATION, {6'h3F, 8'd0});
				end
				2: begin
					write_reg(REG_VALLEY_DEPTH, 14'h3FFF);
					write_reg(REG_MIN_SEPARATION, {6'h00, 8'hFF});
				end
				3: begin
					write_reg(REG_VALLEY_DEPTH, CFG_DATA_BITS'($urandom_range(0, 400)));
					write_reg(REG_MIN_SEPARATION, CFG_DATA_BITS'($urandom_range(0, 16383)));
				end
				4: begin
					write_reg(REG_VALLEY_DEPTH, CFG_DATA_BITS'(VALLEY_DEPTH_RST));
					write_reg(REG_MIN_SEPARATION, CFG_DATA_BITS'(MIN_SEPARATION_RST));
				end
				5: begin
					write_reg(REG_VALLEY_DEPTH, 14'd0);
					write_reg(REG_MIN_SEPARATION, {6'h00, 8'hFF});
				end
				default: begin
					write_reg(REG_VALLEY_DEPTH, CFG_DATA_BITS'($urandom_range(0, 16383)));
					write_reg(REG_MIN_SEPARATION, CFG_DATA_BITS'($urandom_range(0, 60)));
				end
			endcase
			if (phase % 8 != 0)
				settings++;
			quiet = (phase % 8 == 2);
			for (t = 0; t < 3; t++) begin
				roll = $urandom_range(99);
				if (roll < 15)
					shape = SHAPE_NOISE;
				else if (roll < 60)
					shape = SHAPE_SINGLE;
				else
					shape = SHAPE_DOUBLE;
				roll = $urandom_range(99);
				if (t == 1 && (phase % 8 == 3 || phase % 8 == 6)) begin
					len = $urandom_range(MAX_SAMPLES_DEF + 1, MAX_SAMPLES_DEF + 40);
					overlong_traces++;
				end else if (roll < 12) begin
					len = $urandom_range(1, PREGATE_DEF - 1);
				end else begin
					len = $urandom_range(26, 60);
				end
				run_trace(shape, len);
			end
			phase++;
		end
		quiet = 1'b0;

		settle();
		repeat (10) @(posedge clk);
		$display("Checked %0d pulses from %0d samples in %0d traces under %0d settings.",
			sb.results_seen, items_sent, traces_sent, settings);
		$display("%0d pulses carried pileup; %0d traces ran past the sample window.",
			sb.pileups_seen, overlong_traces);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
